@@ hdl/pjh_pkg.sv @@
// Package for the pairwise joint histogram unit.
// Field widths, register indexes, queue command type, back-end states and level decode.
// No dependencies.
package pjh_pkg;

	localparam int RESP_W        = 4;
	localparam int ADDR_W        = 13;
	localparam int BIN_COUNT_W   = 32;
	localparam int NUM_ITEMS_W   = 4;
	localparam int LEVEL_CODES_W = 32;
	localparam int CFG_DATA_W    = 32;
	localparam int CFG_INDEX_W   = 1;
	localparam int ITEM_CNT_W    = 5;
	localparam int LVL_CODE_W    = 4;
	localparam int SLOT_W        = 3;
	localparam int PACKED_ITEMS  = 8;
	localparam int LVL_W         = 7;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_NUM_ITEMS   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_CODES = 1'b1;

	typedef enum logic {
		KIND_RESPONSE = 1'b0,
		KIND_READ     = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [ADDR_W-1:0]     addr;
		logic                  count;
		logic                  row_done;
		logic                  bad;
		logic [ITEM_CNT_W-1:0] n_items;
	} pjh_cmd_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_EMIT,
		B_PAIR_MUL,
		B_PAIR_RD,
		B_PAIR_WR
	} back_state_t;

	// level count of an item; items past the packed register use top
	function automatic logic [LVL_W-1:0] item_levels(input logic [LEVEL_CODES_W-1:0] codes,
		input logic [ITEM_CNT_W-1:0] item, input logic [LVL_W-1:0] top);
		logic [LVL_CODE_W-1:0] code;
		code = codes[{item[SLOT_W-1:0], 2'b00} +: LVL_CODE_W];
		if (item < ITEM_CNT_W'(PACKED_ITEMS)) begin
			item_levels = LVL_W'(code) + LVL_W'(1);
		end else begin
			item_levels = top;
		end
	endfunction

endpackage

@@ hdl/pjh_front.sv @@
// Front end: accepts items, tracks the row in progress and classifies each item
// into a command for the back end. Depends on pjh_pkg.
module pjh_front
	import pjh_pkg::*;
#(
	parameter int MAX_ITEMS  = 8,
	parameter int MAX_LEVELS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               kind,
	input  logic [RESP_W-1:0]                  response,
	input  logic [ADDR_W-1:0]                  bin_address,
	input  logic [NUM_ITEMS_W-1:0]             num_items,
	input  logic [LEVEL_CODES_W-1:0]           level_codes,
	input  logic                               clearing,
	input  logic                               q_full,
	output logic                               push,
	output pjh_cmd_t                           push_cmd,
	output logic [MAX_ITEMS-1:0][RESP_W-1:0]   push_row
);

	localparam int IW = $clog2(MAX_ITEMS);

	logic [IW-1:0]                    pos_q;
	logic                             invalid_q;
	logic [MAX_ITEMS-1:0][RESP_W-1:0] row_q;
	logic [MAX_ITEMS-1:0][RESP_W-1:0] row_next;
	logic [ITEM_CNT_W-1:0]            n_act;
	logic [ITEM_CNT_W-1:0]            pos_ext;
	logic [LVL_W-1:0]                 lv;
	logic                             accept;
	logic                             is_resp;
	logic                             bad;
	logic                             last;

	always_comb begin
		n_act = ITEM_CNT_W'(num_items);
		if (n_act < ITEM_CNT_W'(2)) begin
			n_act = ITEM_CNT_W'(2);
		end else if (n_act > ITEM_CNT_W'(MAX_ITEMS)) begin
			n_act = ITEM_CNT_W'(MAX_ITEMS);
		end
	end

	assign pos_ext  = ITEM_CNT_W'(pos_q);
	assign lv       = item_levels(level_codes, pos_ext, LVL_W'(MAX_LEVELS));
	assign bad      = LVL_W'(response) >= lv;
	assign last     = (pos_ext + ITEM_CNT_W'(1)) >= n_act;
	assign is_resp  = kind_t'(kind) == KIND_RESPONSE;
	assign in_stall = clearing || q_full;
	assign accept   = in_valid && !in_stall;
	assign push     = accept;

	always_comb begin
		row_next        = row_q;
		row_next[pos_q] = response;
	end

	always_comb begin
		push_cmd.kind     = kind_t'(kind);
		push_cmd.addr     = bin_address;
		push_cmd.row_done = is_resp && last;
		push_cmd.bad      = is_resp && bad;
		push_cmd.count    = is_resp && last && !invalid_q && !bad;
		push_cmd.n_items  = n_act;
	end

	assign push_row = row_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			invalid_q <= 1'b0;
		end else if (accept && is_resp) begin
			if (last) begin
				pos_q     <= '0;
				invalid_q <= 1'b0;
			end else begin
				pos_q     <= pos_q + IW'(1);
				invalid_q <= invalid_q || bad;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_resp) begin
			row_q <= row_next;
		end
	end

endmodule

@@ hdl/pjh_queue.sv @@
// Two-entry command queue between front and back end.
// Depends on pjh_pkg.
module pjh_queue
	import pjh_pkg::*;
#(
	parameter int MAX_ITEMS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  pjh_cmd_t                         push_cmd,
	input  logic [MAX_ITEMS-1:0][RESP_W-1:0] push_row,
	output logic                             full,
	input  logic                             pop,
	output logic                             head_valid,
	output pjh_cmd_t                         head_cmd,
	output logic [MAX_ITEMS-1:0][RESP_W-1:0] head_row
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pjh_cmd_t                         cmd_q [QUEUE_DEPTH];
	logic [MAX_ITEMS-1:0][RESP_W-1:0] row_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]                 wr_ptr_q;
	logic [PTR_W-1:0]                 rd_ptr_q;
	logic [CNT_W-1:0]                 count_q;

	assign full       = count_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = cmd_q[rd_ptr_q];
	assign head_row   = row_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_ptr_q] <= push_cmd;
			row_q[wr_ptr_q] <= push_row;
		end
	end

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CNT_W'(QUEUE_DEPTH)))
		else $error("command pushed into a full queue");
	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && !pop) |=> head_valid)
		else $error("queued command lost without pop");
`endif

endmodule

@@ hdl/pjh_back.sv @@
// Back end: count memory with its clearing pass, pair read-modify-write sequencer,
// bin reads and the result register. Depends on pjh_pkg.
module pjh_back
	import pjh_pkg::*;
#(
	parameter int MAX_ITEMS   = 8,
	parameter int MAX_LEVELS  = 16,
	parameter int BIN_DEPTH   = 8192,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             head_valid,
	input  pjh_cmd_t                         head_cmd,
	input  logic [MAX_ITEMS-1:0][RESP_W-1:0] head_row,
	output logic                             pop,
	input  logic [LEVEL_CODES_W-1:0]         level_codes,
	output logic                             clearing,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [BIN_COUNT_W-1:0]           bin_count,
	output logic                             row_done,
	output logic                             bad_response
);

	localparam int AW      = $clog2(BIN_DEPTH);
	localparam int IW      = $clog2(MAX_ITEMS);
	localparam int LT      = (MAX_LEVELS > (1 << LVL_CODE_W)) ? MAX_LEVELS : (1 << LVL_CODE_W);
	localparam int SPAN_W  = $clog2(MAX_ITEMS * MAX_ITEMS * LT * LT);
	localparam int W1      = (SPAN_W > AW) ? SPAN_W : AW;
	localparam int W2      = (W1 > ADDR_W) ? W1 : ADDR_W;
	localparam int IDX_W   = W2 + 1;
	localparam int PROD_W  = LVL_W + RESP_W;
	localparam int STEP_W  = 2 * LVL_W;

	back_state_t                      state_q;
	back_state_t                      state_d;
	pjh_cmd_t                         cmd_q;
	logic [MAX_ITEMS-1:0][RESP_W-1:0] row_q;
	logic [IW-1:0]                    a_q;
	logic [IW-1:0]                    b_q;
	logic [IDX_W-1:0]                 base_q;
	logic [PROD_W-1:0]                prod_q;
	logic [STEP_W-1:0]                step_q;
	logic [AW-1:0]                    idx_q;
	logic                             hit_q;
	logic                             read_hit_q;
	logic [AW-1:0]                    clr_q;
	logic [COUNT_WIDTH-1:0]           rdata_q;
	logic [COUNT_WIDTH-1:0]           mem [BIN_DEPTH];
	logic                             out_valid_q;
	logic [BIN_COUNT_W-1:0]           bin_count_q;
	logic                             row_done_q;
	logic                             bad_q;

	logic [RESP_W-1:0]     x_a;
	logic [RESP_W-1:0]     x_b;
	logic [LVL_W-1:0]      la;
	logic [LVL_W-1:0]      lb;
	logic [ITEM_CNT_W-1:0] a_ext;
	logic [ITEM_CNT_W-1:0] b_ext;
	logic [ITEM_CNT_W-1:0] a_plus2;
	logic [IDX_W-1:0]      idx;
	logic [IDX_W-1:0]      head_idx;
	logic                  idx_hit;
	logic                  head_hit;
	logic                  more_b;
	logic                  more_a;
	logic                  clr_last;
	logic                  sat;
	logic                  out_free;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [COUNT_WIDTH-1:0] mem_wdata;
	logic                  out_load;

	assign x_a      = row_q[a_q];
	assign x_b      = row_q[b_q];
	assign a_ext    = ITEM_CNT_W'(a_q);
	assign b_ext    = ITEM_CNT_W'(b_q);
	assign a_plus2  = a_ext + ITEM_CNT_W'(2);
	assign la       = item_levels(level_codes, a_ext, LVL_W'(MAX_LEVELS));
	assign lb       = item_levels(level_codes, b_ext, LVL_W'(MAX_LEVELS));
	assign idx      = base_q + IDX_W'(x_a) + IDX_W'(prod_q);
	assign idx_hit  = idx < IDX_W'(BIN_DEPTH);
	assign head_idx = IDX_W'(head_cmd.addr);
	assign head_hit = head_idx < IDX_W'(BIN_DEPTH);
	assign more_b   = (b_ext + ITEM_CNT_W'(1)) < cmd_q.n_items;
	assign more_a   = a_plus2 < cmd_q.n_items;
	assign clr_last = clr_q == AW'(BIN_DEPTH - 1);
	assign sat      = rdata_q == '1;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_CLEAR: begin
				if (clr_last) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (head_valid) begin
					if (head_cmd.kind == KIND_READ) begin
						state_d = B_EMIT;
					end else if (head_cmd.count) begin
						state_d = B_PAIR_MUL;
					end else begin
						state_d = B_EMIT;
					end
				end
			end
			B_EMIT: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			B_PAIR_MUL: state_d = B_PAIR_RD;
			B_PAIR_RD:  state_d = B_PAIR_WR;
			B_PAIR_WR: begin
				if (more_b || more_a) begin
					state_d = B_PAIR_MUL;
				end else begin
					state_d = B_EMIT;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop       = (state_q == B_IDLE) && head_valid;
		clearing  = state_q == B_CLEAR;
		out_load  = (state_q == B_EMIT) && out_free;
		rd_en     = 1'b0;
		rd_addr   = idx[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = rdata_q + COUNT_WIDTH'(1);
		case (state_q)
			B_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			B_IDLE: begin
				rd_en   = head_valid && (head_cmd.kind == KIND_READ) && head_hit;
				rd_addr = head_idx[AW-1:0];
			end
			B_PAIR_RD: begin
				rd_en = idx_hit;
			end
			B_PAIR_WR: begin
				mem_we = hit_q && !sat;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q      <= head_cmd;
			row_q      <= head_row;
			read_hit_q <= head_hit;
			a_q        <= '0;
			b_q        <= IW'(1);
			base_q     <= '0;
		end
		case (state_q)
			B_PAIR_MUL: begin
				prod_q <= PROD_W'(la) * PROD_W'(x_b);
				step_q <= STEP_W'(la) * STEP_W'(lb);
			end
			B_PAIR_RD: begin
				idx_q  <= idx[AW-1:0];
				hit_q  <= idx_hit;
				base_q <= base_q + IDX_W'(step_q);
			end
			B_PAIR_WR: begin
				if (more_b) begin
					b_q <= b_q + IW'(1);
				end else begin
					a_q <= a_q + IW'(1);
					b_q <= a_plus2[IW-1:0];
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			bin_count_q <= ((cmd_q.kind == KIND_READ) && read_hit_q) ?
				BIN_COUNT_W'(rdata_q) : '0;
			row_done_q  <= cmd_q.row_done;
			bad_q       <= cmd_q.bad;
		end
	end

	assign out_valid    = out_valid_q;
	assign bin_count    = bin_count_q;
	assign row_done     = row_done_q;
	assign bad_response = bad_q;

`ifndef SYNTHESIS
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CLEAR) |-> !out_valid_q)
		else $error("result valid during clearing pass");
	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_PAIR_WR) |-> $past(state_q == B_PAIR_RD))
		else $error("pair write without preceding read");
	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == B_EMIT))
		else $error("result loaded outside emit");
`endif

endmodule

@@ hdl/pairwise_joint_histogram_unit.sv @@
// Top level of the pairwise joint histogram unit: configuration registers,
// front end, command queue and back end. Depends on pjh_pkg, pjh_front, pjh_queue, pjh_back.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  in       | in_valid / in_stall        | kind, response, bin_address
//  out      | out_valid / out_stall      | bin_count, row_done, bad_response
//  cfg      | cfg_write                  | cfg_index, cfg_data
//
// A read or a response that does not count a row goes from idle to the emit state, which waits
// for a free output register. A counted row does one read-modify-write of the single count
// memory per pair of items, through the multiply, read and write states, before its emit.
// After reset a clearing pass zeroes the counts; in_stall is high meanwhile.
// Once cleared, the front end stalls only when the two-entry queue is full; results wait in
// one output register.
module pairwise_joint_histogram_unit
	import pjh_pkg::*;
#(
	parameter int MAX_ITEMS   = 8,
	parameter int MAX_LEVELS  = 16,
	parameter int BIN_DEPTH   = 8192,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   kind,
	input  logic [RESP_W-1:0]      response,
	input  logic [ADDR_W-1:0]      bin_address,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [BIN_COUNT_W-1:0] bin_count,
	output logic                   row_done,
	output logic                   bad_response,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [NUM_ITEMS_W-1:0]           num_items_q;
	logic [LEVEL_CODES_W-1:0]         level_codes_q;
	logic                             clearing;
	logic                             q_full;
	logic                             push;
	pjh_cmd_t                         push_cmd;
	logic [MAX_ITEMS-1:0][RESP_W-1:0] push_row;
	logic                             pop;
	logic                             head_valid;
	pjh_cmd_t                         head_cmd;
	logic [MAX_ITEMS-1:0][RESP_W-1:0] head_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_items_q   <= NUM_ITEMS_W'(2);
			level_codes_q <= '1;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_NUM_ITEMS:   num_items_q   <= cfg_data[NUM_ITEMS_W-1:0];
				REG_LEVEL_CODES: level_codes_q <= cfg_data[LEVEL_CODES_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pjh_front #(
		.MAX_ITEMS  (MAX_ITEMS),
		.MAX_LEVELS (MAX_LEVELS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.response    (response),
		.bin_address (bin_address),
		.num_items   (num_items_q),
		.level_codes (level_codes_q),
		.clearing    (clearing),
		.q_full      (q_full),
		.push        (push),
		.push_cmd    (push_cmd),
		.push_row    (push_row)
	);

	pjh_queue #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_row   (push_row),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.head_row   (head_row)
	);

	pjh_back #(
		.MAX_ITEMS   (MAX_ITEMS),
		.MAX_LEVELS  (MAX_LEVELS),
		.BIN_DEPTH   (BIN_DEPTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_cmd     (head_cmd),
		.head_row     (head_row),
		.pop          (pop),
		.level_codes  (level_codes_q),
		.clearing     (clearing),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.bin_count    (bin_count),
		.row_done     (row_done),
		.bad_response (bad_response)
	);

endmodule

@@ verif/pairwise_joint_histogram_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for pairwise_joint_histogram_unit: directed and random rows and bin
// reads, checked against an in-bench count table. Depends on pjh_pkg and the unit's RTL.
module pairwise_joint_histogram_unit_tb;
	import pjh_pkg::*;

	localparam int BINS = 8192;
	localparam int ROW_MAX = 8;
	localparam int LEVEL_MAX = 16;

	typedef struct packed {
		logic [BIN_COUNT_W-1:0] count;
		logic                   done;
		logic                   bad;
	} bin_result_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	kind_t                  kind = KIND_RESPONSE;
	logic [RESP_W-1:0]      response = '0;
	logic [ADDR_W-1:0]      bin_address = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [BIN_COUNT_W-1:0] bin_count;
	logic                   row_done;
	logic                   bad_response;
	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_NUM_ITEMS;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// in-bench copy of the unit's state
	bit [BIN_COUNT_W-1:0] bin_tally [BINS];
	bit [RESP_W-1:0]      row_slots [ROW_MAX];
	int unsigned          row_pos = 0;
	bit                   row_flagged = 0;
	bit [3:0]             num_items_reg = 4'd2;
	bit [31:0]            level_codes_reg = 32'hFFFF_FFFF;

	bin_result_t          awaited_results[$];
	int unsigned          recent_bins[$];
	int                   mismatches = 0;
	bit                   gap_calm = 0;
	bit                   stall_calm = 0;

	pairwise_joint_histogram_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .response(response), .bin_address(bin_address),
		.out_valid(out_valid), .out_stall(out_stall),
		.bin_count(bin_count), .row_done(row_done), .bad_response(bad_response),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int unsigned active_items();
		int unsigned n;
		n = num_items_reg;
		if (n < 2) n = 2;
		if (n > ROW_MAX) n = ROW_MAX;
		return n;
	endfunction

	function automatic int unsigned levels_of(int unsigned item);
		if (item >= 8) return LEVEL_MAX;
		return int'(level_codes_reg[4*item +: 4]) + 1;
	endfunction

	task automatic tally_row(int unsigned n);
		int unsigned base;
		int unsigned idx;
		int unsigned la;
		int unsigned lb;
		base = 0;
		for (int unsigned a = 0; a < n; a++) begin
			la = levels_of(a);
			for (int unsigned b = a + 1; b < n; b++) begin
				lb = levels_of(b);
				idx = base + row_slots[a] + la * row_slots[b];
				if (idx < BINS && bin_tally[idx] != '1) begin
					bin_tally[idx]++;
					recent_bins.push_back(idx);
					if (recent_bins.size() > 64) void'(recent_bins.pop_front());
				end
				base += la * lb;
			end
		end
	endtask

	task automatic predict_histogram(kind_t k, logic [RESP_W-1:0] resp, logic [ADDR_W-1:0] addr);
		bin_result_t r;
		int unsigned n;
		int unsigned pos;
		r = '0;
		if (k == KIND_READ) begin
			if (addr < BINS) r.count = bin_tally[addr];
		end else begin
			n = active_items();
			pos = row_pos % ROW_MAX;
			r.bad = (resp >= levels_of(pos));
			row_slots[pos] = resp;
			if (r.bad) row_flagged = 1;
			if (pos + 1 >= n) begin
				if (!row_flagged) tally_row(n);
				row_pos = 0;
				row_flagged = 0;
				r.done = 1'b1;
			end else begin
				row_pos = (pos + 1) % ROW_MAX;
			end
		end
		awaited_results.push_back(r);
	endtask

	task automatic flag_mismatch(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic send_item(kind_t k, logic [RESP_W-1:0] resp, logic [ADDR_W-1:0] addr);
		int unsigned gap;
		gap = gap_calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		response <= resp;
		bin_address <= addr;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_histogram(k, resp, addr);
	endtask

	task automatic send_response(logic [RESP_W-1:0] resp);
		send_item(KIND_RESPONSE, resp, ADDR_W'($urandom_range(0, BINS - 1)));
	endtask

	task automatic read_bin(int unsigned addr);
		send_item(KIND_READ, RESP_W'($urandom_range(0, 15)), ADDR_W'(addr));
	endtask

	// wait for every result, then for the back end to finish its last row
	task automatic settle();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0 || in_stall !== 1'b0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic reconfigure(logic [31:0] n_word, logic [31:0] codes);
		cfg_write <= 1'b1;
		cfg_index <= REG_NUM_ITEMS;
		cfg_data <= n_word;
		@(posedge clk);
		cfg_index <= REG_LEVEL_CODES;
		cfg_data <= codes;
		@(posedge clk);
		cfg_write <= 1'b0;
		num_items_reg = n_word[3:0];
		level_codes_reg = codes;
	endtask

	initial begin : result_checker
		int unsigned hold;
		bin_result_t want;
		wait (arst_n === 1'b1);
		forever begin
			hold = stall_calm ? 0 : $urandom_range(0, 6);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (awaited_results.size() == 0) begin
				flag_mismatch("result with no item outstanding");
			end else begin
				want = awaited_results.pop_front();
				if (bin_count !== want.count)
					flag_mismatch($sformatf("bin_count %0d, want %0d", bin_count, want.count));
				if (row_done !== want.done)
					flag_mismatch($sformatf("row_done %b, want %b", row_done, want.done));
				if (bad_response !== want.bad)
					flag_mismatch($sformatf("bad_response %b, want %b", bad_response, want.bad));
			end
		end
	end

	// reset values: store cleared, two items of sixteen levels
	task automatic check_cleared_store();
		settle();
		read_bin(0);
		read_bin(BINS - 1);
		send_response(4'd0);
		send_response(4'd15);
		read_bin(240);
	endtask

	task automatic check_full_row_extremes();
		settle();
		reconfigure(32'd8, 32'hFFFF_FFFF);
		repeat (8) send_response(4'd15);
		read_bin(255);
		read_bin(7167);
	endtask

	// one level per item: any nonzero response drops the row
	task automatic check_bad_response();
		settle();
		reconfigure(32'd3, 32'h0000_0000);
		send_response(4'd0);
		send_response(4'd1);
		send_response(4'd0);
		send_response(4'd0);
		send_response(4'd0);
		send_response(4'd0);
		read_bin(0);
	endtask

	// count above the maximum acts as eight; then lowered below two mid-row
	task automatic check_item_count_limits();
		settle();
		reconfigure(32'd15, 32'hFFFF_FFFF);
		send_response(4'd3);
		send_response(4'd4);
		send_response(4'd5);
		send_response(4'd6);
		send_response(4'd7);
		settle();
		reconfigure(32'd1, 32'hFFFF_FFFF);
		send_response(4'd9);
		read_bin(67);
	endtask

	task automatic check_random_rows();
		int unsigned sent;
		int unsigned pick;
		logic [31:0] n_word;
		logic [31:0] codes;
		for (int p = 0; p < 6; p++) begin
			settle();
			case (p % 4)
				0: begin
					n_word = 32'd8;
					codes = 32'hFFFF_FFFF;
				end
				1: begin
					n_word = $urandom;
					for (int i = 0; i < 8; i++) codes[4*i +: 4] = $urandom_range(0, 3);
				end
				2: begin
					n_word = $urandom_range(0, 15);
					codes = $urandom;
				end
				default: begin
					n_word = $urandom_range(9, 15);
					codes = $urandom;
				end
			endcase
			reconfigure(n_word, codes);
			gap_calm = ($urandom_range(0, 3) == 0);
			stall_calm = ($urandom_range(0, 3) == 0);
			sent = 0;
			while (sent < 175) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					do begin
						if ($urandom_range(0, 19) == 0)
							send_response(RESP_W'($urandom_range(0, 15)));
						else
							send_response(RESP_W'($urandom_range(0, levels_of(row_pos) - 1)));
						sent++;
					end while (row_pos != 0);
				end else if (recent_bins.size() != 0 && $urandom_range(0, 1) == 0) begin
					read_bin(recent_bins[$urandom_range(0, recent_bins.size() - 1)]);
					sent++;
				end else begin
					read_bin($urandom_range(0, BINS - 1));
					sent++;
				end
			end
			// leave a row open across the next register write
			if (p % 3 == 1)
				repeat ($urandom_range(1, 3)) send_response(RESP_W'($urandom_range(0, 1)));
		end
		gap_calm = 0;
		stall_calm = 0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		check_cleared_store();
		check_full_row_extremes();
		check_bad_response();
		check_item_count_limits();
		check_random_rows();
		settle();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ pairwise_joint_histogram_unit.f @@
hdl/pjh_pkg.sv
hdl/pjh_front.sv
hdl/pjh_queue.sv
hdl/pjh_back.sv
hdl/pairwise_joint_histogram_unit.sv
verif/pairwise_joint_histogram_unit_tb.sv
